[design/i2r_pkg.sv]
package i2r_pkg;

  localparam int VALUE_W = 12;
  localparam int CHAR_W  = 7;
  localparam int STEP_W  = 5;

  localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

  // ASCII symbols
  localparam logic [CHAR_W-1:0] CH_I = 7'h49;
  localparam logic [CHAR_W-1:0] CH_V = 7'h56;
  localparam logic [CHAR_W-1:0] CH_X = 7'h58;
  localparam logic [CHAR_W-1:0] CH_L = 7'h4C;
  localparam logic [CHAR_W-1:0] CH_C = 7'h43;
  localparam logic [CHAR_W-1:0] CH_D = 7'h44;
  localparam logic [CHAR_W-1:0] CH_M = 7'h4D;
  localparam logic [CHAR_W-1:0] CH_NONE = 7'h00;

  // Microprogram step addresses; a pair uses two steps (first char, second char)
  localparam logic [STEP_W-1:0] S_M   = 5'd0;
  localparam logic [STEP_W-1:0] S_CM  = 5'd1;
  localparam logic [STEP_W-1:0] S_CM2 = 5'd2;
  localparam logic [STEP_W-1:0] S_D   = 5'd3;
  localparam logic [STEP_W-1:0] S_CD  = 5'd4;
  localparam logic [STEP_W-1:0] S_CD2 = 5'd5;
  localparam logic [STEP_W-1:0] S_C   = 5'd6;
  localparam logic [STEP_W-1:0] S_XC  = 5'd7;
  localparam logic [STEP_W-1:0] S_XC2 = 5'd8;
  localparam logic [STEP_W-1:0] S_L   = 5'd9;
  localparam logic [STEP_W-1:0] S_XL  = 5'd10;
  localparam logic [STEP_W-1:0] S_XL2 = 5'd11;
  localparam logic [STEP_W-1:0] S_X   = 5'd12;
  localparam logic [STEP_W-1:0] S_IX  = 5'd13;
  localparam logic [STEP_W-1:0] S_IX2 = 5'd14;
  localparam logic [STEP_W-1:0] S_V   = 5'd15;
  localparam logic [STEP_W-1:0] S_IV  = 5'd16;
  localparam logic [STEP_W-1:0] S_IV2 = 5'd17;
  localparam logic [STEP_W-1:0] S_I   = 5'd18;

  // One control word: test rem >= kval; if taken emit ch and optionally subtract.
  typedef struct packed {
    logic [VALUE_W-1:0] kval;
    logic [CHAR_W-1:0]  ch;
    logic               sub;
    logic [STEP_W-1:0]  next_t;
    logic [STEP_W-1:0]  next_f;
  } ucode_t;

  // Sequencer -> datapath
  typedef struct packed {
    logic   load;
    logic   run;
    logic   err;
    ucode_t uw;
  } dp_ctrl_t;

  // Datapath -> sequencer
  typedef struct packed {
    logic taken;
    logic done;
    logic bad_value;
  } dp_stat_t;

  function automatic ucode_t mk(input logic [VALUE_W-1:0] k, input logic [CHAR_W-1:0] c,
                                input logic s, input logic [STEP_W-1:0] t,
                                input logic [STEP_W-1:0] f);
    ucode_t w;
    w.kval   = k;
    w.ch     = c;
    w.sub    = s;
    w.next_t = t;
    w.next_f = f;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      S_M:     w = mk(12'd1000, CH_M, 1'b1, S_M,   S_CM);
      S_CM:    w = mk(12'd900,  CH_C, 1'b0, S_CM2, S_D);
      S_CM2:   w = mk(12'd900,  CH_M, 1'b1, S_XC,  S_XC);
      S_D:     w = mk(12'd500,  CH_D, 1'b1, S_C,   S_CD);
      S_CD:    w = mk(12'd400,  CH_C, 1'b0, S_CD2, S_C);
      S_CD2:   w = mk(12'd400,  CH_D, 1'b1, S_XC,  S_XC);
      S_C:     w = mk(12'd100,  CH_C, 1'b1, S_C,   S_XC);
      S_XC:    w = mk(12'd90,   CH_X, 1'b0, S_XC2, S_L);
      S_XC2:   w = mk(12'd90,   CH_C, 1'b1, S_IX,  S_IX);
      S_L:     w = mk(12'd50,   CH_L, 1'b1, S_X,   S_XL);
      S_XL:    w = mk(12'd40,   CH_X, 1'b0, S_XL2, S_X);
      S_XL2:   w = mk(12'd40,   CH_L, 1'b1, S_IX,  S_IX);
      S_X:     w = mk(12'd10,   CH_X, 1'b1, S_X,   S_IX);
      S_IX:    w = mk(12'd9,    CH_I, 1'b0, S_IX2, S_V);
      S_IX2:   w = mk(12'd9,    CH_X, 1'b1, S_I,   S_I);
      S_V:     w = mk(12'd5,    CH_V, 1'b1, S_I,   S_IV);
      S_IV:    w = mk(12'd4,    CH_I, 1'b0, S_IV2, S_I);
      S_IV2:   w = mk(12'd4,    CH_V, 1'b1, S_I,   S_I);
      S_I:     w = mk(12'd1,    CH_I, 1'b1, S_I,   S_I);
      default: w = mk(12'd1,    CH_I, 1'b1, S_I,   S_I);
    endcase
    return w;
  endfunction

endpackage

[design/integer_to_roman_encoder_top.sv]
// Integer to Roman numeral encoder. A transaction is taken when start is high
// and busy is low; value (1..3999) is turned into its Roman numeral, one ASCII
// character per strobe cycle, greatest symbol first, last_char on the final
// one. The receiver cannot stall: every character is on the result ports for
// exactly one cycle. A value of 0 or above 3999 gives one result with
// range_error and last_char set and char_code zero. Conversion is run by a
// 19-step microprogram that tests the remainder against 1000, 900, 500, 400,
// 100, 90, 50, 40, 10, 9, 5, 4, 1 in turn; each step emits a character when
// its test passes. A numeral takes one step per character plus one per failed
// test (at most 12 failed tests), and 3333 takes the most steps. Busy drops as
// the final result is registered, so the next start may be taken while it is
// displayed.
module integer_to_roman_encoder_top
  import i2r_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] value,
  output logic               busy,
  output logic               strobe,
  output logic [CHAR_W-1:0]  char_code,
  output logic               last_char,
  output logic               range_error
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // Step counter, microcode table and transaction control
  i2r_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // Remainder register, compare/subtract, registered result ports
  i2r_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .ctrl        (ctrl),
    .stat        (stat),
    .strobe      (strobe),
    .char_code   (char_code),
    .last_char   (last_char),
    .range_error (range_error)
  );

endmodule

[design/i2r_seq.sv]
module i2r_seq
  import i2r_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output logic     busy,
  output dp_ctrl_t ctrl
);

  logic              err_pend;
  logic [STEP_W-1:0] pc;
  logic              accept;

  assign accept = start && !busy;

  always_comb begin
    ctrl.load = accept;
    ctrl.run  = busy && !err_pend;
    ctrl.err  = busy && err_pend;
    ctrl.uw   = ucode_rom(pc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      err_pend <= 1'b0;
      pc       <= S_M;
    end else if (accept) begin
      busy     <= 1'b1;
      err_pend <= stat.bad_value;
      pc       <= S_M;
    end else if (busy) begin
      if (err_pend || stat.done) begin
        busy <= 1'b0;
      end
      pc <= stat.taken ? ctrl.uw.next_t : ctrl.uw.next_f;
    end
  end

endmodule

[design/i2r_datapath.sv]
module i2r_datapath
  import i2r_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [VALUE_W-1:0] value,
  input  dp_ctrl_t           ctrl,
  output dp_stat_t           stat,
  output logic               strobe,
  output logic [CHAR_W-1:0]  char_code,
  output logic               last_char,
  output logic               range_error
);

  logic [VALUE_W-1:0] rem;
  logic [VALUE_W-1:0] diff;

  assign diff = rem - ctrl.uw.kval;

  always_comb begin
    stat.taken     = rem >= ctrl.uw.kval;
    stat.done      = stat.taken && ctrl.uw.sub && (diff == '0);
    stat.bad_value = (value == '0) || (value > MAX_VALUE);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= value;
    end else if (ctrl.run && stat.taken && ctrl.uw.sub) begin
      rem <= diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctrl.err || (ctrl.run && stat.taken);
    end
  end

  always_ff @(posedge clk) begin
    char_code   <= ctrl.err ? CH_NONE : ctrl.uw.ch;
    last_char   <= ctrl.err || stat.done;
    range_error <= ctrl.err;
  end

endmodule
